// ----- rtl/vsdo_pkg.sv -----
// vsdo_pkg: shared types, constants and the digit glyph table for the
// video shape and digit overlay. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package vsdo_pkg;

  localparam int COORD_BITS       = 12;
  localparam int FRAME_COUNT_BITS = 16;
  localparam int COLOR_BITS       = 24;
  localparam int MODE_BITS        = 3;
  localparam int DIGIT_BITS       = 4;
  localparam int CFG_INDEX_BITS   = 3;
  localparam int CFG_DATA_BITS    = 24;

  // glyph geometry
  localparam int FONTX     = 2;
  localparam int FONTY     = 3;
  localparam int FONT_HALF = FONTY / 2;
  localparam int GLYPH_W   = FONTX + 1;
  localparam int GLYPH_H   = FONTY + 1;
  localparam int GLYPH_XB  = $clog2(GLYPH_W);
  localparam int GLYPH_YB  = $clog2(GLYPH_H);
  localparam int GLYPH_PIX = GLYPH_W * GLYPH_H;
  localparam int GLYPH_IB  = $clog2(GLYPH_PIX);
  localparam int MAX_DIGIT = 9;

  // draw modes
  localparam logic [MODE_BITS-1:0] MODE_NONE  = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_LINE  = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_RECT  = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_FILL  = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_DIGIT = 3'd4;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_DRAW_MODE   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DRAW_COLOR  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_START_X     = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_START_Y     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_END_X       = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_END_Y       = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DIGIT_VALUE = 3'd6;

  typedef struct packed {
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  frame_start;
    logic                  line_end;
  } in_item_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0]       out_color;
    logic                        out_frame_start;
    logic                        out_line_end;
    logic [COORD_BITS-1:0]       column;
    logic [COORD_BITS-1:0]       row;
    logic [FRAME_COUNT_BITS-1:0] frame_count;
  } out_item_t;

  typedef struct packed {
    logic [MODE_BITS-1:0]  draw_mode;
    logic [COLOR_BITS-1:0] draw_color;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    logic [DIGIT_BITS-1:0] digit_value;
  } cfg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0]       column;
    logic [COORD_BITS-1:0]       row;
    logic [FRAME_COUNT_BITS-1:0] frames;
  } pos_t;

  // lit pixels of each digit, bit index row * GLYPH_W + col,
  // each row written as {col2, col1, col0}, row 3 leftmost
  function automatic logic [GLYPH_PIX-1:0] glyph_mask(input logic [DIGIT_BITS-1:0] digit);
    logic [GLYPH_PIX-1:0] m;
    begin
      case (digit)
        4'd0:    m = {3'b111, 3'b101, 3'b101, 3'b111};
        4'd1:    m = {3'b100, 3'b100, 3'b100, 3'b100};
        4'd2:    m = {3'b111, 3'b001, 3'b111, 3'b111};
        4'd3:    m = {3'b111, 3'b100, 3'b111, 3'b111};
        4'd4:    m = {3'b100, 3'b100, 3'b111, 3'b101};
        4'd5:    m = {3'b111, 3'b100, 3'b111, 3'b111};
        4'd6:    m = {3'b111, 3'b101, 3'b111, 3'b111};
        4'd7:    m = {3'b100, 3'b100, 3'b100, 3'b111};
        4'd8:    m = {3'b111, 3'b101, 3'b111, 3'b111};
        4'd9:    m = {3'b111, 3'b100, 3'b111, 3'b111};
        default: m = '0;
      endcase
      return m;
    end
  endfunction

endpackage
`default_nettype wire

// ----- rtl/vsdo_position.sv -----
// vsdo_position: column, row and frame counters updated once per accepted item.
// Depends on vsdo_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vsdo_position (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire logic          frame_start,
  input  wire logic          line_end,
  output vsdo_pkg::pos_t     pos_nxt
);

  logic [vsdo_pkg::COORD_BITS-1:0]       col_r;
  logic [vsdo_pkg::COORD_BITS-1:0]       row_r;
  logic [vsdo_pkg::FRAME_COUNT_BITS-1:0] frames_r;
  logic                                  prev_le_r;

  always_comb begin
    pos_nxt.column = col_r + 1'b1;
    pos_nxt.row    = row_r;
    pos_nxt.frames = frames_r;
    if (prev_le_r) begin
      pos_nxt.row    = row_r + 1'b1;
      pos_nxt.column = '0;
    end
    if (frame_start) begin
      pos_nxt.column = '0;
      pos_nxt.row    = '0;
      pos_nxt.frames = frames_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      frames_r  <= '0;
      prev_le_r <= 1'b0;
    end else if (accept) begin
      col_r     <= pos_nxt.column;
      row_r     <= pos_nxt.row;
      frames_r  <= pos_nxt.frames;
      prev_le_r <= line_end;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/vsdo_shape.sv -----
// vsdo_shape: decides whether a pixel position lies on the configured shape.
// Depends on vsdo_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vsdo_shape (
  input  wire vsdo_pkg::cfg_t                   cfg,
  input  wire logic [vsdo_pkg::COORD_BITS-1:0]  column,
  input  wire logic [vsdo_pkg::COORD_BITS-1:0]  row,
  output logic                                  hit
);

  localparam int CB = vsdo_pkg::COORD_BITS;
  localparam int PB = 2 * CB;

  logic          x_in, y_in, box_hit, line_hit, outline_hit, glyph_hit;
  logic [CB-1:0] dpx, dpy, dbx, dby;
  logic [PB-1:0] lhs, rhs;
  logic          gx_in, gy_in;
  logic [vsdo_pkg::GLYPH_PIX-1:0] gmask;
  logic [vsdo_pkg::GLYPH_IB-1:0]  gidx;

  always_comb begin
    x_in    = (column >= cfg.start_x) && (column <= cfg.end_x);
    y_in    = (row >= cfg.start_y) && (row <= cfg.end_y);
    box_hit = x_in && y_in;

    // collinearity inside the bounding box
    dpx = column - cfg.start_x;
    dpy = row - cfg.start_y;
    dbx = cfg.end_x - cfg.start_x;
    dby = cfg.end_y - cfg.start_y;
    lhs = PB'(dpy) * PB'(dbx);
    rhs = PB'(dpx) * PB'(dby);
    line_hit = box_hit && (lhs == rhs);

    outline_hit = (x_in && ((row == cfg.start_y) || (row == cfg.end_y))) ||
                  (y_in && ((column == cfg.start_x) || (column == cfg.end_x)));

    // glyph cell relative to the origin, no wrap
    gx_in = (column >= cfg.start_x) && (dpx <= CB'(vsdo_pkg::FONTX));
    gy_in = (row >= cfg.start_y) && (dpy <= CB'(vsdo_pkg::FONTY));
    gidx  = vsdo_pkg::GLYPH_IB'(dpy[vsdo_pkg::GLYPH_YB-1:0]) *
            vsdo_pkg::GLYPH_IB'(vsdo_pkg::GLYPH_W) +
            vsdo_pkg::GLYPH_IB'(dpx[vsdo_pkg::GLYPH_XB-1:0]);
    gmask = vsdo_pkg::glyph_mask(cfg.digit_value);
    glyph_hit = gx_in && gy_in && (cfg.digit_value <= vsdo_pkg::DIGIT_BITS'(vsdo_pkg::MAX_DIGIT))
                && gmask[gidx];

    case (cfg.draw_mode)
      vsdo_pkg::MODE_LINE:  hit = line_hit;
      vsdo_pkg::MODE_RECT:  hit = outline_hit;
      vsdo_pkg::MODE_FILL:  hit = box_hit;
      vsdo_pkg::MODE_DIGIT: hit = glyph_hit;
      default:              hit = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/video_shape_digit_overlay.sv -----
// video_shape_digit_overlay: top level with config registers, input stage and
// result register. Depends on vsdo_pkg, vsdo_position and vsdo_shape.
// Path: an accepted item is registered in the input stage, then in the result register on out_data.
// Throughput: one item per cycle while out_stall is low, set by the two-stage valid pipeline.
// Reset: synchronous active-low rst_n clears counters, valids and config
// registers to zero; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module video_shape_digit_overlay (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire vsdo_pkg::in_item_t                  in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output vsdo_pkg::out_item_t                      out_data,
  input  wire logic                                cfg_we,
  input  wire logic [vsdo_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [vsdo_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int CB = vsdo_pkg::COORD_BITS;

  vsdo_pkg::cfg_t      cfg_r;
  vsdo_pkg::pos_t      pos_nxt;
  vsdo_pkg::pos_t      s1_pos_r;
  vsdo_pkg::in_item_t  s1_item_r;
  vsdo_pkg::out_item_t out_data_r;
  logic                s1_valid_r;
  logic                out_valid_r;
  logic                adv_out, adv_s1, accept, hit;

  assign adv_out  = !out_valid_r || !out_stall;
  assign adv_s1   = !s1_valid_r || adv_out;
  assign in_stall = !adv_s1;
  assign accept   = in_valid && adv_s1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        vsdo_pkg::REG_DRAW_MODE:   cfg_r.draw_mode   <= cfg_data[vsdo_pkg::MODE_BITS-1:0];
        vsdo_pkg::REG_DRAW_COLOR:  cfg_r.draw_color  <= cfg_data[vsdo_pkg::COLOR_BITS-1:0];
        vsdo_pkg::REG_START_X:     cfg_r.start_x     <= cfg_data[CB-1:0];
        vsdo_pkg::REG_START_Y:     cfg_r.start_y     <= cfg_data[CB-1:0];
        vsdo_pkg::REG_END_X:       cfg_r.end_x       <= cfg_data[CB-1:0];
        vsdo_pkg::REG_END_Y:       cfg_r.end_y       <= cfg_data[CB-1:0];
        vsdo_pkg::REG_DIGIT_VALUE: cfg_r.digit_value <= cfg_data[vsdo_pkg::DIGIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  vsdo_position u_position (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .frame_start (in_data.frame_start),
    .line_end    (in_data.line_end),
    .pos_nxt     (pos_nxt)
  );

  vsdo_shape u_shape (
    .cfg    (cfg_r),
    .column (s1_pos_r.column),
    .row    (s1_pos_r.row),
    .hit    (hit)
  );

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv_s1) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_data;
      s1_pos_r  <= pos_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_out) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && s1_valid_r) begin
      out_data_r.out_color       <= hit ? cfg_r.draw_color : s1_item_r.pixel_color;
      out_data_r.out_frame_start <= s1_item_r.frame_start;
      out_data_r.out_line_end    <= s1_item_r.line_end;
      out_data_r.column          <= s1_pos_r.column;
      out_data_r.row             <= s1_pos_r.row;
      out_data_r.frame_count     <= s1_pos_r.frames;
    end
  end

endmodule
`default_nettype wire

// ----- verif/tb_video_shape_digit_overlay.sv -----
// tb_video_shape_digit_overlay: self-checking testbench for the shape and digit overlay.
// Depends on vsdo_pkg and video_shape_digit_overlay; predicts every output pixel in place.
`timescale 1ns / 1ps
module tb_video_shape_digit_overlay;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int RANDOM_PIXELS = 400;
  localparam int REPORT_LIMIT  = 10;

  localparam logic [vsdo_pkg::CFG_INDEX_BITS-1:0] REG_UNUSED     = 3'd7;
  localparam logic [vsdo_pkg::MODE_BITS-1:0]      MODE_UNUSED_LO = 3'd5;
  localparam logic [vsdo_pkg::MODE_BITS-1:0]      MODE_UNUSED_HI = 3'd7;
  localparam logic [vsdo_pkg::DIGIT_BITS-1:0]     DIGIT_BLANK_LO =
    vsdo_pkg::DIGIT_BITS'(vsdo_pkg::MAX_DIGIT + 1);
  localparam logic [vsdo_pkg::DIGIT_BITS-1:0]     DIGIT_BLANK_HI = '1;
  localparam logic [vsdo_pkg::COORD_BITS-1:0]     COORD_TOP      = '1;

  logic                                clk       = 1'b0;
  logic                                rst_n     = 1'b0;
  logic                                in_valid  = 1'b0;
  logic                                in_stall;
  vsdo_pkg::in_item_t                  in_data   = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  vsdo_pkg::out_item_t                 out_data;
  logic                                cfg_we    = 1'b0;
  logic [vsdo_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [vsdo_pkg::CFG_DATA_BITS-1:0]  cfg_data  = '0;

  // predictor state and register shadow
  vsdo_pkg::cfg_t                        shape_cfg         = '0;
  logic [vsdo_pkg::COORD_BITS-1:0]       col_pos           = '0;
  logic [vsdo_pkg::COORD_BITS-1:0]       row_pos           = '0;
  logic                                  last_was_line_end = 1'b0;
  logic [vsdo_pkg::FRAME_COUNT_BITS-1:0] frame_total       = '0;
  vsdo_pkg::out_item_t                   expected_pixels[$];

  int  pixels_sent    = 0;
  int  results_seen   = 0;
  int  mismatch_count = 0;
  int  cycle_count    = 0;
  logic pacing_on     = 1'b1;

  video_shape_digit_overlay dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------- geometry

  function automatic logic in_rect(input int unsigned px, py, ax, ay, bx, by);
    return px >= ax && px <= bx && py >= ay && py <= by;
  endfunction

  function automatic logic on_segment(input int unsigned px, py, ax, ay, bx, by);
    longint unsigned lhs;
    longint unsigned rhs;
    if (!in_rect(px, py, ax, ay, bx, by)) return 1'b0;
    lhs = 64'(py - ay);
    lhs = lhs * 64'(bx - ax);
    rhs = 64'(px - ax);
    rhs = rhs * 64'(by - ay);
    return lhs == rhs;
  endfunction

  function automatic logic on_border(input int unsigned px, py, ax, ay, bx, by);
    return (px >= ax && px <= bx && (py == ay || py == by)) ||
           (py >= ay && py <= by && (px == ax || px == bx));
  endfunction

  // glyph corners stay at full width so they never wrap
  function automatic logic on_digit(input int unsigned px, py);
    int unsigned x0, y0, xr, ym, yb;
    logic top, mid, low, right, left_up, box;
    x0      = 32'(shape_cfg.start_x);
    y0      = 32'(shape_cfg.start_y);
    xr      = x0 + vsdo_pkg::FONTX;
    ym      = y0 + vsdo_pkg::FONT_HALF;
    yb      = y0 + vsdo_pkg::FONTY;
    top     = on_segment(px, py, x0, y0, xr, y0);
    mid     = on_segment(px, py, x0, ym, xr, ym);
    low     = on_segment(px, py, x0, yb, xr, yb);
    right   = on_segment(px, py, xr, y0, xr, yb);
    left_up = on_segment(px, py, x0, y0, x0, ym);
    box     = on_border(px, py, x0, y0, xr, yb);
    case (shape_cfg.digit_value)
      4'd0: return box;
      4'd1: return right;
      4'd2: return top | mid | low | on_segment(px, py, xr, y0, xr, ym) |
                   on_segment(px, py, x0, ym, x0, yb);
      4'd3: return top | mid | low | right;
      4'd4: return left_up | mid | right;
      4'd5: return top | mid | low | left_up | on_segment(px, py, xr, ym, xr, yb);
      4'd6: return top | left_up | on_border(px, py, x0, ym, xr, yb);
      4'd7: return top | right;
      4'd8: return mid | box;
      4'd9: return on_border(px, py, x0, y0, xr, ym) |
                   on_segment(px, py, xr, ym, xr, yb) | low;
      default: return 1'b0;
    endcase
  endfunction

  task automatic predict_overlay(input vsdo_pkg::in_item_t pix);
    vsdo_pkg::out_item_t res;
    logic                hit;
    int unsigned         px, py, ax, ay, bx, by;
    col_pos = col_pos + 1'b1;
    if (last_was_line_end) begin
      row_pos = row_pos + 1'b1;
      col_pos = '0;
    end
    last_was_line_end = pix.line_end;
    if (pix.frame_start) begin
      col_pos     = '0;
      row_pos     = '0;
      frame_total = frame_total + 1'b1;
    end
    px = 32'(col_pos);
    py = 32'(row_pos);
    ax = 32'(shape_cfg.start_x);
    ay = 32'(shape_cfg.start_y);
    bx = 32'(shape_cfg.end_x);
    by = 32'(shape_cfg.end_y);
    case (shape_cfg.draw_mode)
      vsdo_pkg::MODE_LINE:  hit = on_segment(px, py, ax, ay, bx, by);
      vsdo_pkg::MODE_RECT:  hit = on_border(px, py, ax, ay, bx, by);
      vsdo_pkg::MODE_FILL:  hit = in_rect(px, py, ax, ay, bx, by);
      vsdo_pkg::MODE_DIGIT: hit = on_digit(px, py);
      default:              hit = 1'b0;
    endcase
    res.out_color       = hit ? shape_cfg.draw_color : pix.pixel_color;
    res.out_frame_start = pix.frame_start;
    res.out_line_end    = pix.line_end;
    res.column          = col_pos;
    res.row             = row_pos;
    res.frame_count     = frame_total;
    expected_pixels.push_back(res);
  endtask

  // ---------------------------------------------------------------- checking

  task automatic compare_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("item %0d %s: expected %0h, got %0h", results_seen, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    vsdo_pkg::out_item_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_pixels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected item: color %0h column %0d row %0d",
                   out_data.out_color, out_data.column, out_data.row);
      end else begin
        want = expected_pixels.pop_front();
        compare_field("color", 32'(want.out_color), 32'(out_data.out_color));
        compare_field("frame_start", 32'(want.out_frame_start),
                      32'(out_data.out_frame_start));
        compare_field("line_end", 32'(want.out_line_end), 32'(out_data.out_line_end));
        compare_field("column", 32'(want.column), 32'(out_data.column));
        compare_field("row", 32'(want.row), 32'(out_data.row));
        compare_field("frame_count", 32'(want.frame_count), 32'(out_data.frame_count));
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------- driving

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 30));
  endfunction

  initial begin : stall_gen
    int n;
    forever begin
      @(negedge clk);
      if (pacing_on && $urandom_range(0, 3) == 0) begin
        n = pick_gap();
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic vsdo_pkg::in_item_t make_pixel(
      input logic [vsdo_pkg::COLOR_BITS-1:0] color, input logic fs, le);
    vsdo_pkg::in_item_t pix;
    pix.pixel_color = color;
    pix.frame_start = fs;
    pix.line_end    = le;
    return pix;
  endfunction

  task automatic send_pixel(input vsdo_pkg::in_item_t pix);
    int gap;
    gap = (pacing_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= pix;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predict_overlay(pix);
    pixels_sent++;
  endtask

  task automatic send_frame(input int width, height, input logic with_start);
    for (int r = 0; r < height; r++) begin
      for (int c = 0; c < width; c++) begin
        send_pixel(make_pixel(vsdo_pkg::COLOR_BITS'($urandom),
                              with_start && r == 0 && c == 0, c == width - 1));
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [vsdo_pkg::CFG_INDEX_BITS-1:0] index,
                           input logic [vsdo_pkg::CFG_DATA_BITS-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (index)
      vsdo_pkg::REG_DRAW_MODE:   shape_cfg.draw_mode   = value[vsdo_pkg::MODE_BITS-1:0];
      vsdo_pkg::REG_DRAW_COLOR:  shape_cfg.draw_color  = value[vsdo_pkg::COLOR_BITS-1:0];
      vsdo_pkg::REG_START_X:     shape_cfg.start_x     = value[vsdo_pkg::COORD_BITS-1:0];
      vsdo_pkg::REG_START_Y:     shape_cfg.start_y     = value[vsdo_pkg::COORD_BITS-1:0];
      vsdo_pkg::REG_END_X:       shape_cfg.end_x       = value[vsdo_pkg::COORD_BITS-1:0];
      vsdo_pkg::REG_END_Y:       shape_cfg.end_y       = value[vsdo_pkg::COORD_BITS-1:0];
      vsdo_pkg::REG_DIGIT_VALUE: shape_cfg.digit_value = value[vsdo_pkg::DIGIT_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [vsdo_pkg::MODE_BITS-1:0] mode,
                           input int sx, sy, ex, ey, digit);
    write_reg(vsdo_pkg::REG_DRAW_MODE, vsdo_pkg::CFG_DATA_BITS'(mode));
    write_reg(vsdo_pkg::REG_DRAW_COLOR, vsdo_pkg::CFG_DATA_BITS'($urandom));
    write_reg(vsdo_pkg::REG_START_X, vsdo_pkg::CFG_DATA_BITS'(sx));
    write_reg(vsdo_pkg::REG_START_Y, vsdo_pkg::CFG_DATA_BITS'(sy));
    write_reg(vsdo_pkg::REG_END_X, vsdo_pkg::CFG_DATA_BITS'(ex));
    write_reg(vsdo_pkg::REG_END_Y, vsdo_pkg::CFG_DATA_BITS'(ey));
    write_reg(vsdo_pkg::REG_DIGIT_VALUE, vsdo_pkg::CFG_DATA_BITS'(digit));
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_position_tracking();
    send_pixel(make_pixel('0, 1'b0, 1'b0));
    send_pixel(make_pixel('1, 1'b0, 1'b1));
    send_pixel(make_pixel(vsdo_pkg::COLOR_BITS'($urandom), 1'b0, 1'b0));
    send_pixel(make_pixel(vsdo_pkg::COLOR_BITS'($urandom), 1'b1, 1'b1));
    send_pixel(make_pixel(vsdo_pkg::COLOR_BITS'($urandom), 1'b0, 1'b0));
  endtask

  // upper data bits must be dropped, unused index must change nothing
  task automatic test_register_masking();
    wait_drained();
    write_reg(vsdo_pkg::REG_DRAW_MODE, {21'h1FFFFF, vsdo_pkg::MODE_FILL});
    write_reg(vsdo_pkg::REG_DRAW_COLOR, '1);
    write_reg(vsdo_pkg::REG_START_X, 24'hFFF000);
    write_reg(vsdo_pkg::REG_START_Y, 24'hABC000);
    write_reg(vsdo_pkg::REG_END_X, 24'h123001);
    write_reg(vsdo_pkg::REG_END_Y, 24'h800001);
    write_reg(vsdo_pkg::REG_DIGIT_VALUE, 24'hFFFFF3);
    write_reg(REG_UNUSED, vsdo_pkg::CFG_DATA_BITS'($urandom));
    send_frame(2, 2, 1'b1);
  endtask

  task automatic test_shape_modes();
    wait_drained();
    configure(vsdo_pkg::MODE_LINE, 0, 0, 2, 2, 0);
    send_frame(2, 2, 1'b1);
    wait_drained();
    configure(vsdo_pkg::MODE_RECT, 0, 0, 2, 2, 0);
    send_frame(2, 2, 1'b1);
    wait_drained();
    configure(vsdo_pkg::MODE_DIGIT, 0, 0, 0, 0, 8);
    send_frame(2, 2, 1'b1);
  endtask

  task automatic test_pass_through();
    wait_drained();
    configure(MODE_UNUSED_LO, 0, 0, int'(COORD_TOP), int'(COORD_TOP), 0);
    send_frame(1, 1, 1'b1);
    wait_drained();
    write_reg(vsdo_pkg::REG_DRAW_MODE, vsdo_pkg::CFG_DATA_BITS'(MODE_UNUSED_HI));
    send_frame(1, 1, 1'b1);
    wait_drained();
    configure(vsdo_pkg::MODE_DIGIT, 0, 0, 0, 0, int'(DIGIT_BLANK_LO));
    send_frame(1, 1, 1'b1);
    wait_drained();
    write_reg(vsdo_pkg::REG_DIGIT_VALUE, vsdo_pkg::CFG_DATA_BITS'(DIGIT_BLANK_HI));
    send_frame(1, 1, 1'b1);
  endtask

  task automatic test_reversed_corners();
    wait_drained();
    configure(vsdo_pkg::MODE_RECT, 3, 0, 0, 1, 0);
    send_frame(2, 1, 1'b1);
    wait_drained();
    write_reg(vsdo_pkg::REG_DRAW_MODE, vsdo_pkg::CFG_DATA_BITS'(vsdo_pkg::MODE_FILL));
    send_frame(1, 1, 1'b1);
  endtask

  task automatic test_glyph_edge();
    wait_drained();
    configure(vsdo_pkg::MODE_DIGIT, int'(COORD_TOP) - 1, 0, 0, 0, 0);
    send_frame(1, 2, 1'b1);
    wait_drained();
    configure(vsdo_pkg::MODE_DIGIT, 0, int'(COORD_TOP) - 1, 0, 0, 0);
    send_frame(2, 1, 1'b1);
  endtask

  function automatic logic [vsdo_pkg::COORD_BITS-1:0] pick_coord(input int span);
    int r;
    r = int'($urandom_range(0, 9));
    if (r == 0) return '0;
    if (r == 1) return COORD_TOP;
    return vsdo_pkg::COORD_BITS'($urandom_range(0, span + 2));
  endfunction

  task automatic randomize_shape(input int width, height);
    logic [vsdo_pkg::CFG_DATA_BITS-1:0] value;
    int                                 r;
    r = int'($urandom_range(0, 9));
    value = vsdo_pkg::CFG_DATA_BITS'($urandom);
    case (r)
      0:       value[vsdo_pkg::MODE_BITS-1:0] = vsdo_pkg::MODE_NONE;
      1, 2:    value[vsdo_pkg::MODE_BITS-1:0] = vsdo_pkg::MODE_LINE;
      3, 4:    value[vsdo_pkg::MODE_BITS-1:0] = vsdo_pkg::MODE_RECT;
      5, 6:    value[vsdo_pkg::MODE_BITS-1:0] = vsdo_pkg::MODE_FILL;
      7, 8:    value[vsdo_pkg::MODE_BITS-1:0] = vsdo_pkg::MODE_DIGIT;
      default: value[vsdo_pkg::MODE_BITS-1:0] =
                 vsdo_pkg::MODE_BITS'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
    endcase
    write_reg(vsdo_pkg::REG_DRAW_MODE, value);
    if ($urandom_range(0, 3) != 0)
      write_reg(vsdo_pkg::REG_DRAW_COLOR, vsdo_pkg::CFG_DATA_BITS'($urandom));
    value = vsdo_pkg::CFG_DATA_BITS'($urandom);
    value[vsdo_pkg::COORD_BITS-1:0] = pick_coord(width);
    if ($urandom_range(0, 3) != 0) write_reg(vsdo_pkg::REG_START_X, value);
    value[vsdo_pkg::COORD_BITS-1:0] = pick_coord(height);
    if ($urandom_range(0, 3) != 0) write_reg(vsdo_pkg::REG_START_Y, value);
    value[vsdo_pkg::COORD_BITS-1:0] = pick_coord(width);
    if ($urandom_range(0, 3) != 0) write_reg(vsdo_pkg::REG_END_X, value);
    value[vsdo_pkg::COORD_BITS-1:0] = pick_coord(height);
    if ($urandom_range(0, 3) != 0) write_reg(vsdo_pkg::REG_END_Y, value);
    r = int'($urandom_range(0, 13));
    value[vsdo_pkg::DIGIT_BITS-1:0] = (r <= vsdo_pkg::MAX_DIGIT) ?
      vsdo_pkg::DIGIT_BITS'(r) :
      vsdo_pkg::DIGIT_BITS'($urandom_range(DIGIT_BLANK_LO, DIGIT_BLANK_HI));
    if ($urandom_range(0, 3) != 0) write_reg(vsdo_pkg::REG_DIGIT_VALUE, value);
    if ($urandom_range(0, 7) == 0)
      write_reg(REG_UNUSED, vsdo_pkg::CFG_DATA_BITS'($urandom));
  endtask

  task automatic test_random_scenes();
    int target, width, height, kind, n;
    target = pixels_sent + RANDOM_PIXELS;
    while (pixels_sent < target) begin
      wait_drained();
      pacing_on = ($urandom_range(0, 3) != 0);
      width  = int'($urandom_range(1, 8));
      height = int'($urandom_range(1, 6));
      randomize_shape(width, height);
      kind = int'($urandom_range(0, 9));
      if (kind < 7) begin
        n = int'($urandom_range(1, 2));
        repeat (n) send_frame(width, height, 1'b1);
      end else if (kind < 9) begin
        // frame without its start flag, counters just carry on
        send_frame(width, height, 1'b0);
      end else begin
        n = int'($urandom_range(3, 20));
        repeat (n) send_pixel(make_pixel(vsdo_pkg::COLOR_BITS'($urandom),
                                         $urandom_range(0, 7) == 0,
                                         $urandom_range(0, 2) == 0));
      end
    end
    pacing_on = 1'b1;
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    test_position_tracking();
    test_register_masking();
    test_shape_modes();
    test_pass_through();
    test_reversed_corners();
    test_glyph_edge();
    test_random_scenes();
    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
